// ===== rtl/uctr_pkg.sv =====
package uctr_pkg;

  localparam int unsigned MaxStepsDefault = 63;
  localparam int unsigned StepW = 6;
  localparam int unsigned CordicIters = 16;
  localparam int unsigned CordicIterW = 4;

  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [16:0] TwoPiQ13 = 17'sd51472;
  localparam logic signed [31:0] HalfPiQ29 = 32'sd843314857;
  localparam logic signed [31:0] CordicGainQ16 = 32'sd39797;
  localparam logic [15:0] DtFloor = 16'd66;

  // register indexes on the config port
  localparam logic [2:0] RegLinMin = 3'd0;
  localparam logic [2:0] RegLinMax = 3'd1;
  localparam logic [2:0] RegAngMin = 3'd2;
  localparam logic [2:0] RegAngMax = 3'd3;
  localparam logic [2:0] RegTimeStep = 3'd4;
  localparam logic [2:0] RegStepCount = 3'd5;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // clamp command, clear pose
    logic mult_start;  // w*dt, first part of the yaw increment
    logic cordic_init; // load CORDIC from current yaw
    logic cordic_iter; // one CORDIC micro-rotation
    logic mul_a;       // v*cos, v*sin
    logic mul_b;       // (.)*dt, rounding
    logic update;      // accumulate pose
    logic dyaw_calc;   // compute yaw increment
  } uctr_cmd_t;

  function automatic logic signed [31:0] atan_q29(input logic [CordicIterW-1:0] i);
    case (i)
      4'd0: atan_q29 = 32'sd421657428;
      4'd1: atan_q29 = 32'sd248918915;
      4'd2: atan_q29 = 32'sd131521918;
      4'd3: atan_q29 = 32'sd66762579;
      4'd4: atan_q29 = 32'sd33510843;
      4'd5: atan_q29 = 32'sd16771758;
      4'd6: atan_q29 = 32'sd8387925;
      4'd7: atan_q29 = 32'sd4194219;
      4'd8: atan_q29 = 32'sd2097141;
      4'd9: atan_q29 = 32'sd1048575;
      4'd10: atan_q29 = 32'sd524288;
      4'd11: atan_q29 = 32'sd262144;
      4'd12: atan_q29 = 32'sd131072;
      4'd13: atan_q29 = 32'sd65536;
      4'd14: atan_q29 = 32'sd32768;
      default: atan_q29 = 32'sd16384;
    endcase
  endfunction

endpackage

// ===== rtl/uctr_datapath.sv =====
module uctr_datapath import uctr_pkg::*; (
  input  logic               clk_i,
  input  uctr_cmd_t          cmd_i,
  input  logic [CordicIterW-1:0] iter_i,
  input  logic signed [15:0] lin_vel_i,
  input  logic signed [15:0] ang_vel_i,
  input  logic signed [15:0] lin_min_i,
  input  logic signed [15:0] lin_max_i,
  input  logic signed [15:0] ang_min_i,
  input  logic signed [15:0] ang_max_i,
  input  logic [15:0]        dt_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [15:0] heading_o
);

  logic signed [15:0] v_q, w_q, yaw_q;
  logic signed [16:0] dyaw_q;
  logic signed [31:0] x_q, y_q;
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic signed [47:0] pc_q, ps_q;
  logic signed [31:0] dx_q, dy_q;
  logic signed [32:0] wdt_q;
  logic [16:0] dt_s;
  logic signed [15:0] v_c, w_c, t;
  logic signed [31:0] z0, ax, ay, zn;
  logic signed [79:0] rx, ry;
  logic signed [32:0] yr;
  logic signed [17:0] yw, yw_wr;

  assign dt_s = {1'b0, (dt_i < DtFloor) ? DtFloor : dt_i};

  // clamp: min(v,hi) then max with lo
  always_comb begin
    t = (lin_vel_i < lin_max_i) ? lin_vel_i : lin_max_i;
    v_c = (t > lin_min_i) ? t : lin_min_i;
    w_c = (ang_vel_i < ang_max_i) ? ang_vel_i : ang_max_i;
    w_c = (w_c > ang_min_i) ? w_c : ang_min_i;
  end

  always_comb begin
    z0 = {yaw_q, 16'd0};
    ax = cx_q >>> iter_i;
    ay = cy_q >>> iter_i;
    zn = atan_q29(iter_i);
    rx = (pc_q * $signed(dt_s)) + 80'sd134217728;
    ry = (ps_q * $signed(dt_s)) + 80'sd134217728;
    yr = wdt_q + 33'sd16384;
    yw = 18'(yaw_q) + 18'(dyaw_q);
    // wrap yaw once by 2*pi
    if (yw > 18'(PiQ13)) begin
      yw_wr = yw - 18'(TwoPiQ13);
    end else if (yw < -18'(PiQ13)) begin
      yw_wr = yw + 18'(TwoPiQ13);
    end else begin
      yw_wr = yw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q <= v_c;
      w_q <= w_c;
      x_q <= '0;
      y_q <= '0;
      yaw_q <= '0;
    end
    if (cmd_i.mult_start) wdt_q <= 33'(w_q) * 33'($signed(dt_s));
    if (cmd_i.dyaw_calc) dyaw_q <= 17'(yr >>> 15);
    // quadrant prerotation
    if (cmd_i.cordic_init) begin
      if (z0 > HalfPiQ29) begin
        cz_q <= z0 - HalfPiQ29; cx_q <= '0; cy_q <= CordicGainQ16;
      end else if (z0 < -HalfPiQ29) begin
        cz_q <= z0 + HalfPiQ29; cx_q <= '0; cy_q <= -CordicGainQ16;
      end else begin
        cz_q <= z0; cx_q <= CordicGainQ16; cy_q <= '0;
      end
    end
    if (cmd_i.cordic_iter) begin
      if (cz_q >= 0) begin
        cx_q <= cx_q - ay; cy_q <= cy_q + ax; cz_q <= cz_q - zn;
      end else begin
        cx_q <= cx_q + ay; cy_q <= cy_q - ax; cz_q <= cz_q + zn;
      end
    end
    if (cmd_i.mul_a) begin
      pc_q <= 48'(v_q) * 48'(cx_q);
      ps_q <= 48'(v_q) * 48'(cy_q);
    end
    if (cmd_i.mul_b) begin
      dx_q <= 32'(rx >>> 28);
      dy_q <= 32'(ry >>> 28);
    end
    // accumulate, saturate the wrapped yaw
    if (cmd_i.update) begin
      x_q <= x_q + dx_q;
      y_q <= y_q + dy_q;
      if (yw_wr > 18'(PiQ13)) yaw_q <= PiQ13;
      else if (yw_wr < -18'(PiQ13)) yaw_q <= -PiQ13;
      else yaw_q <= 16'(yw_wr);
    end
  end

  assign pos_x_o = x_q;
  assign pos_y_o = y_q;
  assign heading_o = yaw_q;

endmodule

// ===== rtl/uctr_ctrl.sv =====
module uctr_ctrl import uctr_pkg::*; #(
  parameter int unsigned MaxSteps = MaxStepsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic [StepW-1:0] step_count_i,
  output uctr_cmd_t        cmd_o,
  output logic [CordicIterW-1:0] iter_o,
  output logic [StepW-1:0] step_index_o,
  output logic             last_pose_o
);

  typedef enum logic [2:0] {
    Idle, Dyaw, Emit, CInit, CIter, MulA, MulB, Update
  } state_e;

  state_e state_q, state_d;
  logic [CordicIterW-1:0] iter_q, iter_d;
  logic [StepW-1:0] idx_q, idx_d, steps_q, steps_d;
  logic [StepW-1:0] steps_c;

  always_comb begin
    steps_c = step_count_i;
    if (steps_c == '0) steps_c = StepW'(1);
    if (steps_c > StepW'(MaxSteps)) steps_c = StepW'(MaxSteps);
  end

  always_comb begin
    state_d = state_q;
    iter_d = iter_q;
    idx_d = idx_q;
    steps_d = steps_q;
    cmd_o = '0;
    case (state_q)
      Idle: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          steps_d = steps_c;
          idx_d = '0;
          state_d = Dyaw;
        end
      end
      Dyaw: begin
        cmd_o.mult_start = 1'b1;
        state_d = Emit;
      end
      Emit: begin
        if (idx_q == '0) cmd_o.dyaw_calc = 1'b1;
        if (out_ready) begin
          if (idx_q == steps_q) state_d = Idle;
          else state_d = CInit;
        end
      end
      CInit: begin
        cmd_o.cordic_init = 1'b1;
        iter_d = '0;
        state_d = CIter;
      end
      CIter: begin
        cmd_o.cordic_iter = 1'b1;
        iter_d = iter_q + 1'b1;
        if (iter_q == CordicIterW'(CordicIters - 1)) state_d = MulA;
      end
      MulA: begin
        cmd_o.mul_a = 1'b1;
        state_d = MulB;
      end
      MulB: begin
        cmd_o.mul_b = 1'b1;
        state_d = Update;
      end
      Update: begin
        cmd_o.update = 1'b1;
        idx_d = idx_q + 1'b1;
        state_d = Emit;
      end
      default: state_d = Idle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      iter_q <= '0;
      idx_q <= '0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      iter_q <= iter_d;
      idx_q <= idx_d;
      steps_q <= steps_d;
    end
  end

  assign in_ready = (state_q == Idle);
  assign out_valid = (state_q == Emit);
  assign iter_o = iter_q;
  assign step_index_o = idx_q;
  assign last_pose_o = (idx_q == steps_q);

endmodule

// ===== rtl/unicycle_trajectory_rollout.sv =====
// Unicycle trajectory rollout.
// Input channel (in_valid/in_ready) takes one command: lin_vel_i, ang_vel_i,
// Q3.12. Each is clamped to the configured limits. Output channel
// (out_valid/out_ready) gives step_count+1 poses: the start pose (0,0,0),
// then one pose per Euler step; last_pose_o marks the final one.
// Config port: cfg_we_i, cfg_idx_i, cfg_data_i; write only while idle.
// Indexes: 0 lin min, 1 lin max, 2 ang min, 3 ang max, 4 dt, 5 step count.
// Step count is clamped to 1..MaxSteps. Order: w*dt, then the start pose;
// each further step runs CORDIC prerotation, 16 shared CORDIC iterations,
// two multiply stages and accumulate, then offers its pose. The next item
// is taken after the last pose transfer.
// Reset clears the controller and config registers to their defaults.
// A stalled receiver holds the current pose; the rollout waits on it.
module unicycle_trajectory_rollout import uctr_pkg::*; #(
  parameter int unsigned MaxSteps = MaxStepsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] lin_vel_i,
  input  logic signed [15:0] ang_vel_i,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [15:0] heading_o,
  output logic [StepW-1:0]   step_index_o,
  output logic               last_pose_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);

  logic signed [15:0] lin_min_q, lin_max_q, ang_min_q, ang_max_q;
  logic [15:0] dt_q;
  logic [StepW-1:0] steps_q;
  uctr_cmd_t cmd;
  logic [CordicIterW-1:0] iter;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_min_q <= 16'sd0;
      lin_max_q <= 16'sd4096;
      ang_min_q <= -16'sd4096;
      ang_max_q <= 16'sd4096;
      dt_q <= 16'd6554;
      steps_q <= StepW'(30);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLinMin: lin_min_q <= cfg_data_i;
        RegLinMax: lin_max_q <= cfg_data_i;
        RegAngMin: ang_min_q <= cfg_data_i;
        RegAngMax: ang_max_q <= cfg_data_i;
        RegTimeStep: dt_q <= cfg_data_i;
        RegStepCount: steps_q <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  uctr_ctrl #(.MaxSteps(MaxSteps)) u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
    .step_count_i(steps_q), .cmd_o(cmd), .iter_o(iter),
    .step_index_o, .last_pose_o
  );

  uctr_datapath u_dp (
    .clk_i, .cmd_i(cmd), .iter_i(iter),
    .lin_vel_i, .ang_vel_i,
    .lin_min_i(lin_min_q), .lin_max_i(lin_max_q),
    .ang_min_i(ang_min_q), .ang_max_i(ang_max_q),
    .dt_i(dt_q), .pos_x_o, .pos_y_o, .heading_o
  );

endmodule
